// File: hw/rtl/rfs_pkg.sv
package rfs_pkg;

  // split modes; any code above blank behaves as a literal separator
  localparam logic [1:0] MODE_NULL  = 2'd0;
  localparam logic [1:0] MODE_BLANK = 2'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 1'd1;

  localparam logic [1:0] SPLIT_MODE_RST = MODE_BLANK;
  localparam logic [7:0] SEPARATOR_RST  = 8'd44;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_record;
  } in_item_t;

  typedef struct packed {
    logic        field_valid;
    logic [15:0] field_number;
    logic [15:0] field_start;
    logic [15:0] field_len;
    logic        record_end;
    logic        too_long;
    logic        last_of_item;
  } out_item_t;

  // results caused by one item, in order
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_set_t;

endpackage

// File: hw/rtl/rfs_split.sv
module rfs_split #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfs_pkg::in_item_t item_i,
  input  logic              go_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        sep_i,
  output rfs_pkg::res_set_t res_o
);

  localparam int unsigned PosW = (OFFSET_BITS >= 16) ? 16 : OFFSET_BITS;
  localparam logic [PosW-1:0] OffMax = '1;

  logic [PosW-1:0] pos_q, pos_d, pstart_q, pstart_d;
  logic            inside_q, inside_d;
  logic [15:0]     fe_q, fe_d;
  logic            ovf_q, ovf_d;

  logic [PosW-1:0] next_pos;
  logic [PosW-1:0] lit_start;
  logic            sat;
  logic            e_byte, e_close, close_fld, closed;
  logic [15:0]     b_start, b_len, c_start, c_len;
  logic [15:0]     fe_byte, fe_close;
  rfs_pkg::out_item_t r_byte, r_close;

  always_comb begin
    sat       = (pos_q == OffMax);
    next_pos  = sat ? pos_q : pos_q + PosW'(1);
    ovf_d     = ovf_q | (item_i.has_byte & sat);
    pos_d     = item_i.has_byte ? next_pos : pos_q;
    pstart_d  = pstart_q;
    inside_d  = inside_q;
    lit_start = inside_q ? pstart_q : '0;
    e_byte    = 1'b0;
    closed    = 1'b0;
    b_start   = '0;
    b_len     = '0;

    if (item_i.has_byte) begin
      case (mode_i)
        rfs_pkg::MODE_NULL: begin
          e_byte  = 1'b1;
          b_start = 16'(pos_q);
          b_len   = 16'(next_pos) - 16'(pos_q);
          closed  = item_i.end_of_record;
        end
        rfs_pkg::MODE_BLANK: begin
          if (item_i.data_byte inside {rfs_pkg::CHAR_SPACE, rfs_pkg::CHAR_TAB,
                                       rfs_pkg::CHAR_NL}) begin
            if (inside_q) begin
              e_byte   = 1'b1;
              b_start  = 16'(pstart_q);
              b_len    = 16'(pos_q) - 16'(pstart_q);
              inside_d = 1'b0;
            end
          end else if (!inside_q) begin
            pstart_d = pos_q;
            inside_d = 1'b1;
          end
        end
        default: begin
          // literal separator byte
          inside_d = 1'b1;
          pstart_d = lit_start;
          if (item_i.data_byte == sep_i) begin
            e_byte   = 1'b1;
            b_start  = 16'(lit_start);
            b_len    = 16'(pos_q) - 16'(lit_start);
            pstart_d = next_pos;
          end
        end
      endcase
    end

    e_close   = item_i.end_of_record & ~closed;
    close_fld = (mode_i != rfs_pkg::MODE_NULL) & inside_d;
    c_start   = close_fld ? 16'(pstart_d) : '0;
    c_len     = close_fld ? 16'(pos_d) - 16'(pstart_d) : '0;

    fe_byte  = (e_byte && fe_q != rfs_pkg::COUNT_MAX) ? fe_q + 16'd1 : fe_q;
    fe_close = (close_fld && fe_byte != rfs_pkg::COUNT_MAX) ? fe_byte + 16'd1 : fe_byte;
    fe_d     = fe_byte;

    r_byte.field_valid  = 1'b1;
    r_byte.field_number = fe_byte;
    r_byte.field_start  = b_start;
    r_byte.field_len    = b_len;
    r_byte.record_end   = closed;
    r_byte.too_long     = ovf_d;
    r_byte.last_of_item = ~e_close;

    r_close.field_valid  = close_fld;
    r_close.field_number = close_fld ? fe_close : '0;
    r_close.field_start  = c_start;
    r_close.field_len    = c_len;
    r_close.record_end   = 1'b1;
    r_close.too_long     = ovf_d;
    r_close.last_of_item = 1'b1;

    res_o.count  = {1'b0, e_byte} + {1'b0, e_close};
    res_o.first  = e_byte ? r_byte : r_close;
    res_o.second = r_close;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pstart_q <= '0;
      inside_q <= 1'b0;
      fe_q     <= '0;
      ovf_q    <= 1'b0;
    end else if (go_i) begin
      if (item_i.end_of_record) begin
        pos_q    <= '0;
        pstart_q <= '0;
        inside_q <= 1'b0;
        fe_q     <= '0;
        ovf_q    <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        pstart_q <= pstart_d;
        inside_q <= inside_d;
        fe_q     <= fe_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

// File: hw/rtl/rfs_res_buf.sv
module rfs_res_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfs_pkg::res_set_t  res_i,
  input  logic               push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rfs_pkg::out_item_t out_item_o
);

  logic [1:0]         cnt_q, cnt_d, rem;
  logic               pop;
  rfs_pkg::out_item_t head_q, head_d, tail_q, tail_d;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = head_q;
  assign pop         = out_valid_o & ~out_stall_i;
  assign rem         = cnt_q - {1'b0, pop};
  // two-entry queue, so a two-result item fits only when it drains empty
  assign room_o      = ({1'b0, rem} + {1'b0, res_i.count}) <= 3'd2;

  always_comb begin
    head_d = pop ? tail_q : head_q;
    tail_d = tail_q;
    cnt_d  = rem;
    if (push_i) begin
      cnt_d = rem + res_i.count;
      case (rem)
        2'd0: begin
          head_d = res_i.first;
          tail_d = res_i.second;
        end
        2'd1: begin
          tail_d = res_i.first;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// File: hw/rtl/record_field_splitter_unit.sv
// path: a result is offered by the two-entry result queue once its item has
// left the input stage register and been pushed; unstalled, it transfers at
// the following edge. throughput: one item per cycle while the queue has
// room; a two-result item needs it empty; it pops one per unstalled cycle
// reset: asynchronous, active low; clears record state, queue and input stage,
// and sets split mode to blank runs and the separator to comma
module record_field_splitter_unit #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rfs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rfs_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rfs_pkg::out_item_t                out_item_o
);

  logic [1:0]        mode_q;
  logic [7:0]        sep_q;
  logic              s1_valid_q;
  rfs_pkg::in_item_t s1_item_q;
  logic              room, s1_go;
  rfs_pkg::res_set_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rfs_pkg::SPLIT_MODE_RST;
      sep_q  <= rfs_pkg::SEPARATOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfs_pkg::CFG_SPLIT_MODE: mode_q <= cfg_data_i[1:0];
        rfs_pkg::CFG_SEPARATOR:  sep_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign s1_go      = s1_valid_q & room;
  assign in_stall_o = s1_valid_q & ~room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_item_i;
    end
  end

  rfs_split #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_split (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(s1_item_q),
    .go_i  (s1_go),
    .mode_i(mode_q),
    .sep_i (sep_q),
    .res_o (res)
  );

  rfs_res_buf u_res_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .push_i     (s1_go),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
